// File: src/nmea_sentence_checksum_classify_top_defines.svh
// Assertion macros shared by the checksum classifier.
`ifndef NMEA_SENTENCE_CHECKSUM_CLASSIFY_TOP_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CLASSIFY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/nscc_pkg.sv
package nscc_pkg;

   localparam logic [7:0]  STAR_CHAR = 8'h2A;
   localparam logic [7:0]  CHAR_A    = 8'h41;
   localparam logic [7:0]  CHAR_C    = 8'h43;
   localparam logic [31:0] WIN_GPGG  = 32'h4750_4747;
   localparam logic [31:0] WIN_GPRM  = 32'h4750_524D;

   typedef enum logic [1:0] {
      KIND_CSUM_ERR = 2'd0,
      KIND_GGA      = 2'd1,
      KIND_RMC      = 2'd2,
      KIND_UNKNOWN  = 2'd3
   } kind_type;

   // One word handed from the input register to the scanner.
   typedef struct packed {
      logic       step;
      logic       last;
      logic [7:0] data;
   } scan_ctrl_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] sum;
   } result_type;

   // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] d;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = {1'b0, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = {1'b0, 4'(b - 8'h57)};
      end else begin
         d = 5'h10;
      end
      return d;
   endfunction

endpackage

// File: src/nscc_scan.sv
module nscc_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  nscc_pkg::scan_ctrl_type ctrl,
   output nscc_pkg::result_type  result
);

   logic        past_first_ff, past_first_in;
   logic [7:0]  xor_ff, xor_in;
   logic        star_ff, star_in;
   logic [7:0]  hex_ff, hex_in;
   logic        hex_end_ff, hex_end_in;
   logic [31:0] win_ff, win_in;
   logic        gga_ff, gga_in;
   logic        rmc_ff, rmc_in;
   logic [4:0]  digit;

   always_comb begin
      digit         = nscc_pkg::hex_digit(ctrl.data);
      gga_in        = gga_ff | (win_ff == nscc_pkg::WIN_GPGG && ctrl.data == nscc_pkg::CHAR_A);
      rmc_in        = rmc_ff | (win_ff == nscc_pkg::WIN_GPRM && ctrl.data == nscc_pkg::CHAR_C);
      xor_in        = xor_ff;
      star_in       = star_ff;
      hex_in        = hex_ff;
      hex_end_in    = hex_end_ff;
      past_first_in = 1'b1;
      win_in        = {win_ff[23:0], ctrl.data};
      if (past_first_ff) begin
         if (!star_ff) begin
            if (ctrl.data == nscc_pkg::STAR_CHAR) begin
               star_in = 1'b1;
            end else begin
               xor_in = xor_ff ^ ctrl.data;
            end
         end else if (!hex_end_ff) begin
            if (!digit[4]) begin
               hex_in = {hex_ff[3:0], digit[3:0]};
            end else begin
               hex_end_in = 1'b1;
            end
         end
      end
      // A missing star or a mismatch wins over any sentence type.
      if (!star_in || xor_in != hex_in) begin
         result.kind = nscc_pkg::KIND_CSUM_ERR;
      end else if (gga_in) begin
         result.kind = nscc_pkg::KIND_GGA;
      end else if (rmc_in) begin
         result.kind = nscc_pkg::KIND_RMC;
      end else begin
         result.kind = nscc_pkg::KIND_UNKNOWN;
      end
      result.sum = xor_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.step && ctrl.last)) begin
         past_first_ff <= 1'b0;
         xor_ff        <= '0;
         star_ff       <= 1'b0;
         hex_ff        <= '0;
         hex_end_ff    <= 1'b0;
         win_ff        <= '0;
         gga_ff        <= 1'b0;
         rmc_ff        <= 1'b0;
      end else if (ctrl.step) begin
         past_first_ff <= past_first_in;
         xor_ff        <= xor_in;
         star_ff       <= star_in;
         hex_ff        <= hex_in;
         hex_end_ff    <= hex_end_in;
         win_ff        <= win_in;
         gga_ff        <= gga_in;
         rmc_ff        <= rmc_in;
      end
   end

endmodule

// File: src/nmea_sentence_checksum_classify_top.sv
// Path: an accepted word is captured in the input register, then folded into the sentence state;
// a final word also fills the result register on rsp_, waiting while it is full and stalled.
// Throughput: one word per cycle, unless a final word waits on a full, stalled result register.
// Reset: synchronous, active high; clears the handshake valids and all sentence state.
`include "nmea_sentence_checksum_classify_top_defines.svh"

// Checks one NMEA sentence, delivered a word (byte) at a time with its last word marked,
// against its transmitted hex checksum and classifies it as a checksum error, GGA, RMC or unknown.
// The design is an input register, a short combinational scan over the running sentence
// state, and a result register. The input register lets the block accept a word while a
// finished result is still waiting on rsp_stall; only a final word, which needs the result
// register, can be held up there.
module nmea_sentence_checksum_classify_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_sentence,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_message_kind,
   output logic [7:0] rsp_computed_sum
);

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // Result register.
   logic                 rsp_valid_ff;
   nscc_pkg::result_type rsp_data_ff;

   logic                    out_free;
   logic                    step;
   nscc_pkg::scan_ctrl_type scan_ctrl;
   nscc_pkg::result_type    scan_result;

   // A non-final word never needs the result register, so it always moves on.
   // A final word moves on when the result register is empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_eos_ff || out_free);
   assign req_stall = in_valid_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_sentence;
      end
   end

   assign scan_ctrl.step = step;
   assign scan_ctrl.last = in_eos_ff;
   assign scan_ctrl.data = in_byte_ff;

   nscc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .result (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_eos_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_eos_ff) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_kind = rsp_data_ff.kind;
   assign rsp_computed_sum = rsp_data_ff.sum;

   // Only a final word waiting on a full, stalled result register holds off the input.
   `NSCC_ASSERT_SAME(a_stall_cause, req_stall, in_valid_ff && in_eos_ff && rsp_valid_ff && rsp_stall, "input stalled without a blocked final word")

   // A word that is not the last of its sentence never produces a result.
   `NSCC_ASSERT_NEXT(a_no_result_mid, step && !in_eos_ff, rsp_valid_ff == $past(rsp_valid_ff && rsp_stall), "result appeared from a non-final word")

   // A newly presented result comes from a final word that was processed.
   `NSCC_ASSERT_SAME(a_result_source, rsp_valid_ff && !$past(rsp_valid_ff), $past(step && in_eos_ff), "result appeared without a final word")

endmodule

// File: bench/tb_nmea_sentence_checksum_classify_top.sv
`timescale 1ns / 1ps

module tb_nmea_sentence_checksum_classify_top;

   // The run stops on its own well before this; it only catches a hung handshake.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned WORD_TARGET  = 1100;
   // The result of a final word passes through the input and result registers; allow some slack.
   localparam int unsigned DRAIN_CYCLES = 10;

   localparam logic [7:0] DOLLAR_CHAR = 8'h24;
   localparam logic [7:0] COMMA_CHAR  = 8'h2C;
   localparam logic [7:0] CR_CHAR     = 8'h0D;
   localparam logic [7:0] LF_CHAR     = 8'h0A;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_sentence = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic [1:0] rsp_message_kind;
   logic [7:0] rsp_computed_sum;

   // Sentence checker and classifier. It keeps its own copy of the sentence state,
   // folds every accepted word into it, and queues the result of each final word.
   class sentence_scoreboard;
      logic        past_first;
      logic [7:0]  xor_sum;
      logic        star_seen;
      logic [7:0]  sent_sum;
      logic        digits_done;
      logic [31:0] last_four;
      logic        gga_seen;
      logic        rmc_seen;
      nscc_pkg::result_type expected_results[$];
      int unsigned errors;

      function void clear_sentence();
         past_first  = 1'b0;
         xor_sum     = 8'h00;
         star_seen   = 1'b0;
         sent_sum    = 8'h00;
         digits_done = 1'b0;
         last_four   = 32'h0;
         gga_seen    = 1'b0;
         rmc_seen    = 1'b0;
      endfunction

      function void note_word(logic [7:0] b, logic last);
         logic       is_hex;
         logic [3:0] nibble;
         nscc_pkg::result_type r;
         if (last_four == nscc_pkg::WIN_GPGG && b == nscc_pkg::CHAR_A) gga_seen = 1'b1;
         if (last_four == nscc_pkg::WIN_GPRM && b == nscc_pkg::CHAR_C) rmc_seen = 1'b1;
         if (past_first) begin
            if (!star_seen) begin
               if (b == nscc_pkg::STAR_CHAR) star_seen = 1'b1;
               else xor_sum = xor_sum ^ b;
            end else if (!digits_done) begin
               is_hex = 1'b1;
               nibble = 4'h0;
               if (b >= "0" && b <= "9") nibble = 4'(b - "0");
               else if (b >= "A" && b <= "F") nibble = 4'(b - "A" + 10);
               else if (b >= "a" && b <= "f") nibble = 4'(b - "a" + 10);
               else is_hex = 1'b0;
               if (is_hex) sent_sum = {sent_sum[3:0], nibble};
               else digits_done = 1'b1;
            end
         end
         past_first = 1'b1;
         last_four  = {last_four[23:0], b};
         if (last) begin
            if (!star_seen || xor_sum != sent_sum) r.kind = nscc_pkg::KIND_CSUM_ERR;
            else if (gga_seen) r.kind = nscc_pkg::KIND_GGA;
            else if (rmc_seen) r.kind = nscc_pkg::KIND_RMC;
            else r.kind = nscc_pkg::KIND_UNKNOWN;
            r.sum = xor_sum;
            expected_results.push_back(r);
            clear_sentence();
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] sum);
         nscc_pkg::result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: kind %0d sum %02h", $time, kind, sum);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (kind !== want.kind) begin
            $display("%0t: message_kind expected %0d actual %0d", $time, want.kind, kind);
            errors++;
         end
         if (sum !== want.sum) begin
            $display("%0t: computed_sum expected %02h actual %02h", $time, want.sum, sum);
            errors++;
         end
      endfunction
   endclass

   sentence_scoreboard sb;
   logic [7:0]  sentence_bytes[$];
   int unsigned words_sent = 0;
   int unsigned cycle_count = 0;
   bit          sender_burst = 1'b0;

   nmea_sentence_checksum_classify_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_sentence (req_end_of_sentence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_message_kind    (rsp_message_kind),
      .rsp_computed_sum    (rsp_computed_sum)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a handshake that never completes ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Hex character for one nibble, in either case.
   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 10) return 8'h30 + n;
      return 8'((lower ? 8'h61 : 8'h41) + n - 10);
   endfunction

   // XOR of everything queued so far except the first byte, which the block skips.
   function automatic logic [7:0] sum_after_first();
      logic [7:0] s;
      s = 8'h00;
      for (int i = 1; i < sentence_bytes.size(); i++) s ^= sentence_bytes[i];
      return s;
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) sentence_bytes.push_back(s[i]);
   endtask

   task automatic add_digits(logic [7:0] v, bit lower);
      sentence_bytes.push_back(hex_char(v[7:4], lower));
      sentence_bytes.push_back(hex_char(v[3:0], lower));
   endtask

   // Printable filler that never contains the star, so the checksum field stays where
   // the generator puts it.
   task automatic add_filler(int unsigned count);
      logic [7:0] c;
      repeat (count) begin
         do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == nscc_pkg::STAR_CHAR);
         sentence_bytes.push_back(c);
      end
   endtask

   // One word on the input channel. The valid stays high straight into the next word
   // when no gap is drawn, so back-to-back words really are back to back.
   task automatic send_word(logic [7:0] b, logic last);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data_byte       <= b;
      req_end_of_sentence <= last;
      // The stall seen here is the value the block presented at this very edge.
      do @(posedge clock); while (req_stall);
      sb.note_word(b, last);
      words_sent++;
   endtask

   task automatic send_sentence();
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < sentence_bytes.size(); i++)
         send_word(sentence_bytes[i], i == sentence_bytes.size() - 1);
   endtask

   // Short hand-built sentences that hit each corner of the checksum and the classifier.
   task automatic run_directed_sentences();
      logic [7:0] s;
      // A one-byte sentence has no room for a star, so it is a checksum error with sum 0.
      sentence_bytes = {8'hFF};
      send_sentence();
      // The leading star is skipped; the second one opens an empty checksum that compares
      // against zero.
      sentence_bytes = {nscc_pkg::STAR_CHAR, nscc_pkg::STAR_CHAR};
      send_sentence();
      // Both texts present with a good checksum: GGA wins over RMC.
      sentence_bytes = {};
      add_text("$GPRMCGPGGA");
      s = sum_after_first();
      sentence_bytes.push_back(nscc_pkg::STAR_CHAR);
      add_digits(s, 1'b0);
      send_sentence();
      // Star as first byte, three lowercase digits of which only the low two count,
      // then a comma and a zero byte that the checksum ignores.
      sentence_bytes = {};
      add_text("*GPRMC");
      s = sum_after_first();
      add_text("*1");
      add_digits(s, 1'b1);
      sentence_bytes.push_back(COMMA_CHAR);
      sentence_bytes.push_back(8'h00);
      send_sentence();
      // A GGA sentence with a wrong checksum must still come back as a checksum error.
      sentence_bytes = {};
      add_text("$GPGGA");
      s = sum_after_first() ^ 8'h5A;
      sentence_bytes.push_back(nscc_pkg::STAR_CHAR);
      add_digits(s, 1'b0);
      send_sentence();
      // No star at all.
      sentence_bytes = {DOLLAR_CHAR, nscc_pkg::CHAR_A};
      send_sentence();
   endtask

   // Most random sentences are well formed with random content; the rest lose their
   // star or digits, carry a wrong checksum, or are plain byte noise.
   task automatic build_random_sentence();
      int unsigned shape;
      int unsigned form;
      int unsigned n;
      logic [7:0]  s;
      logic [7:0]  c;
      bit          lower;
      sentence_bytes = {};
      shape = $urandom_range(0, 99);
      if (shape >= 85) begin
         n = $urandom_range(1, 10);
         repeat (n) sentence_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      sentence_bytes.push_back(($urandom_range(0, 9) == 0) ?
                               8'($urandom_range(0, 255)) : DOLLAR_CHAR);
      add_filler($urandom_range(0, 4));
      case ($urandom_range(0, 5))
         1: add_text("GPGGA");
         2: add_text("GPRMC");
         3: begin
            add_text("GPGGA");
            add_filler($urandom_range(0, 3));
            add_text("GPRMC");
         end
         4: begin
            add_text("GPRMC");
            add_filler($urandom_range(0, 3));
            add_text("GPGGA");
         end
         5: add_text($urandom_range(0, 1) ? "GPGGC" : "GPRMA");
         default: ;
      endcase
      add_filler($urandom_range(0, 4));
      s = sum_after_first();
      lower = 1'($urandom_range(0, 1));
      // Broken forms: 0 drops the star, 1 garbles the digits, 2 leaves the digits out.
      // Good forms: 3 puts extra leading digits in front, the others are plain.
      form = (shape >= 70) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      if (form != 0) sentence_bytes.push_back(nscc_pkg::STAR_CHAR);
      if (form == 1) s ^= 8'($urandom_range(1, 255));
      if (form == 3)
         repeat ($urandom_range(1, 3))
            sentence_bytes.push_back(hex_char(4'($urandom_range(0, 15)), lower));
      if (form != 0 && form != 2) add_digits(s, lower);
      n = $urandom_range(0, 2);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: c = COMMA_CHAR;
            1: c = CR_CHAR;
            2: c = LF_CHAR;
            default: c = 8'($urandom_range(0, 255));
         endcase
         sentence_bytes.push_back(c);
      end
   endtask

   // Result side: a stall of random length before each result, redrawn in runs of eight
   // so that some runs take every result as soon as it appears.
   task automatic drain_results();
      int unsigned gap;
      int unsigned taken;
      bit          no_stall;
      taken = 0;
      no_stall = 1'b0;
      forever begin
         if (taken % 8 == 0) no_stall = ($urandom_range(0, 2) == 0);
         gap = no_stall ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_message_kind, rsp_computed_sum);
         taken++;
      end
   endtask

   initial begin
      sb = new;
      sb.clear_sentence();
      sb.errors = 0;
      // Hold reset from the start, then release it on an edge like every other input.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none
      run_directed_sentences();
      while (words_sent < WORD_TARGET) begin
         build_random_sentence();
         send_sentence();
      end
      req_valid <= 1'b0;
      // Everything is in; wait for the last results, then a little longer so that a
      // stray extra result would still be caught.
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/nscc_pkg.sv
src/nscc_scan.sv
src/nmea_sentence_checksum_classify_top.sv
bench/tb_nmea_sentence_checksum_classify_top.sv
